FILE: sv/hsd_pkg.sv
// Shared types and constants for the hue/saturation delta table.
package hsd_pkg;

  localparam int unsigned CNT_W   = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LIN_W   = 16;  // lum*hue_divs + hue
  localparam int unsigned OFF_W   = 24;  // full linear offset
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [WORD_W-1:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [WORD_W-1:0] ZERO_BITS = 32'h0000_0000;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // register index = paddr[3:2]
  localparam logic [1:0] REG_HUE_DIVS = 2'd0;
  localparam logic [1:0] REG_SAT_DIVS = 2'd1;
  localparam logic [1:0] REG_VAL_DIVS = 2'd2;

  localparam logic [CNT_W-1:0] VAL_DIVS_RST = 8'd1;

  typedef struct packed {
    logic              command;
    logic [CNT_W-1:0]  hue_index;
    logic [CNT_W-1:0]  sat_index;
    logic [CNT_W-1:0]  lum_index;
    logic [WORD_W-1:0] in_hue_shift;
    logic [WORD_W-1:0] in_sat_scale;
    logic [WORD_W-1:0] in_val_scale;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_hue_shift;
    logic [WORD_W-1:0] out_sat_scale;
    logic [WORD_W-1:0] out_val_scale;
    logic              hit;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] hue_shift;
    logic [WORD_W-1:0] sat_scale;
    logic [WORD_W-1:0] val_scale;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] hue_divs;
    logic [CNT_W-1:0] sat_divs;
    logic [CNT_W-1:0] val_divs;
  } cfg_t;

endpackage

FILE: sv/hsd_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface hsd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/hue_sat_delta_table.sv
// Hue/saturation/value delta table: sequencer, offset pipeline and result register.
// Sequence: accept, the two-stage offset multiply (MUL1, MUL2), memory access, then
//   a read-back for reads or a saturation-0 fixup for saturation-1 writes; a result waits
//   until out is free, and a new transaction is taken only once the last has finished.
// Reset: a clearing pass writes zero to all TABLE_ENTRIES entries, one per
//   cycle, with in ready low; configuration writes are taken throughout.
module hue_sat_delta_table #(
  parameter int unsigned TABLE_ENTRIES = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hsd_pkg::PADDR_W-1:0] paddr,
  input  logic [hsd_pkg::PDATA_W-1:0] pwdata,
  output logic [hsd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  hsd_stream_if.sink                  in_i,
  hsd_stream_if.source                out_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
  localparam logic [hsd_pkg::OFF_W-1:0] ENTRIES_OFF = hsd_pkg::OFF_W'(TABLE_ENTRIES);

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,  // post-reset sweep of the table
    S_IDLE  = 7'b0000010,  // waiting for a transaction
    S_MUL1  = 7'b0000100,  // lum*hue_divs + hue, index range check
    S_MUL2  = 7'b0001000,  // *sat_divs + sat, capacity check
    S_ACC   = 7'b0010000,  // main memory access
    S_RD    = 7'b0100000,  // read data back from memory
    S_FIX   = 7'b1000000   // saturation-0 fixup after a saturation-1 write
  } st_e;

  st_e st_q, st_d;

  hsd_pkg::cfg_t cfg;

  logic [AW-1:0] clr_q, clr_d;

  // transaction payload and offset pipeline
  hsd_pkg::in_item_t         item_q;
  logic [hsd_pkg::LIN_W-1:0] lin_q;
  logic                      idx_ok_q;
  logic [AW-1:0]             pos_q;
  logic                      ok_q;
  logic [hsd_pkg::OFF_W-1:0] off;
  logic                      idx_ok;

  // output register
  hsd_pkg::out_item_t out_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic               res_load;
  logic               out_free;

  // memory ports
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  hsd_pkg::entry_t mem_wdata, mem_rdata;
  logic [AW-1:0]   pos0;

  logic accept;

  hsd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready = 1'b1;

  hsd_mem #(
    .DEPTH (TABLE_ENTRIES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready = (st_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // A value count of zero acts as one.
  assign idx_ok = (item_q.hue_index < cfg.hue_divs) &&
                  (item_q.sat_index < cfg.sat_divs) &&
                  ((item_q.lum_index < cfg.val_divs) ||
                   ((cfg.val_divs == '0) && (item_q.lum_index == '0)));

  // Second multiply: at most 16 x 8 bits.
  assign off = hsd_pkg::OFF_W'(lin_q) * hsd_pkg::OFF_W'(cfg.sat_divs) +
               hsd_pkg::OFF_W'(item_q.sat_index);

  // Saturation-0 entry of a saturation-1 write sits one below it.
  assign pos0 = pos_q - AW'(1);

  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos_q;
    mem_raddr = pos_q;
    mem_wdata = '0;
    res_load  = 1'b0;
    res_d     = '0;

    case (st_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LAST_ADDR) begin
          st_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          st_d = S_MUL1;
        end
      end

      S_MUL1: st_d = S_MUL2;

      S_MUL2: st_d = S_ACC;

      S_ACC: begin
        if (item_q.command == hsd_pkg::CMD_READ) begin
          if (ok_q) begin
            mem_re = 1'b1;
            st_d   = S_RD;
          end else if (out_free) begin
            // miss: default 0.0 / 1.0 / 1.0
            res_load            = 1'b1;
            res_d.out_hue_shift = hsd_pkg::ZERO_BITS;
            res_d.out_sat_scale = hsd_pkg::ONE_BITS;
            res_d.out_val_scale = hsd_pkg::ONE_BITS;
            res_d.hit           = 1'b0;
            st_d                = S_IDLE;
          end
        end else if (!ok_q) begin
          if (out_free) begin
            res_load = 1'b1;
            st_d     = S_IDLE;
          end
        end else if (item_q.sat_index == hsd_pkg::CNT_W'(1)) begin
          // store the entry and fetch the saturation-0 neighbor together
          mem_we              = 1'b1;
          mem_wdata.hue_shift = item_q.in_hue_shift;
          mem_wdata.sat_scale = item_q.in_sat_scale;
          mem_wdata.val_scale = item_q.in_val_scale;
          mem_re              = 1'b1;
          mem_raddr           = pos0;
          st_d                = S_FIX;
        end else if (out_free) begin
          mem_we              = 1'b1;
          mem_wdata.hue_shift = item_q.in_hue_shift;
          mem_wdata.sat_scale = item_q.in_sat_scale;
          mem_wdata.val_scale = (item_q.sat_index == '0) ? hsd_pkg::ONE_BITS
                                                         : item_q.in_val_scale;
          res_load            = 1'b1;
          res_d.hit           = 1'b1;
          st_d                = S_IDLE;
        end
      end

      S_RD: begin
        if (out_free) begin
          res_load            = 1'b1;
          res_d.out_hue_shift = mem_rdata.hue_shift;
          res_d.out_sat_scale = mem_rdata.sat_scale;
          res_d.out_val_scale = mem_rdata.val_scale;
          res_d.hit           = 1'b1;
          st_d                = S_IDLE;
        end
      end

      S_FIX: begin
        if (out_free) begin
          if (mem_rdata.val_scale != hsd_pkg::ONE_BITS) begin
            mem_we              = 1'b1;
            mem_waddr           = pos0;
            mem_wdata.hue_shift = item_q.in_hue_shift;
            mem_wdata.sat_scale = item_q.in_sat_scale;
            mem_wdata.val_scale = hsd_pkg::ONE_BITS;
          end
          res_load  = 1'b1;
          res_d.hit = 1'b1;
          st_d      = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and pipeline registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i.data;
    end
    if (st_q == S_MUL1) begin
      lin_q    <= hsd_pkg::LIN_W'(item_q.lum_index) * hsd_pkg::LIN_W'(cfg.hue_divs) +
                  hsd_pkg::LIN_W'(item_q.hue_index);
      idx_ok_q <= idx_ok;
    end
    if (st_q == S_MUL2) begin
      pos_q <= off[AW-1:0];
      ok_q  <= idx_ok_q && (off < ENTRIES_OFF);
    end
    if (res_load) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTH
  // the fixup state is reached only by a write at saturation one
  a_fix_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_FIX |-> item_q.command == hsd_pkg::CMD_WRITE &&
                      item_q.sat_index == hsd_pkg::CNT_W'(1))
    else $error("fixup without saturation-1 write");

  // fixup rewrites the neighbor only when its value scale is not 1.0
  a_fix_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_FIX && mem_we) |-> mem_rdata.val_scale != hsd_pkg::ONE_BITS &&
                                  mem_waddr == pos_q - AW'(1))
    else $error("bad fixup write");

  // a transaction always enters the offset pipeline
  a_accept_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q == S_MUL1)
    else $error("accepted transaction lost");

  // the clearing pass ends only after the last entry
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_CLEAR && st_d == S_IDLE) |-> clr_q == LAST_ADDR)
    else $error("clearing pass cut short");
`endif

endmodule

FILE: sv/hsd_cfg.sv
// APB-style configuration registers: hue, saturation and value counts.
module hsd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [hsd_pkg::PADDR_W-1:0] paddr_i,
  input  logic [hsd_pkg::PDATA_W-1:0] pwdata_i,
  output logic [hsd_pkg::PDATA_W-1:0] prdata_o,
  output hsd_pkg::cfg_t               cfg_o
);

  hsd_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr_i[3:2];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        hsd_pkg::REG_HUE_DIVS: cfg_d.hue_divs = pwdata_i[hsd_pkg::CNT_W-1:0];
        hsd_pkg::REG_SAT_DIVS: cfg_d.sat_divs = pwdata_i[hsd_pkg::CNT_W-1:0];
        hsd_pkg::REG_VAL_DIVS: cfg_d.val_divs = pwdata_i[hsd_pkg::CNT_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_divs <= '0;
      cfg_q.sat_divs <= '0;
      cfg_q.val_divs <= hsd_pkg::VAL_DIVS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      hsd_pkg::REG_HUE_DIVS: prdata_o = hsd_pkg::PDATA_W'(cfg_q.hue_divs);
      hsd_pkg::REG_SAT_DIVS: prdata_o = hsd_pkg::PDATA_W'(cfg_q.sat_divs);
      hsd_pkg::REG_VAL_DIVS: prdata_o = hsd_pkg::PDATA_W'(cfg_q.val_divs);
      default:               prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/hsd_mem.sv
// Table storage: one write port, one read port, registered read data.
module hsd_mem #(
  parameter  int unsigned DEPTH = 8192,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  hsd_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output hsd_pkg::entry_t rdata_o
);

  hsd_pkg::entry_t mem_q [DEPTH];
  hsd_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
